>>> sv/pid_pkg.sv
// Shared types and constants for the PID step block.
// Used by every module of the block; depends on nothing else.
package pid_pkg;

  // Command codes carried on the input channel.
  localparam logic [1:0] CMD_SAMPLE    = 2'd0;
  localparam logic [1:0] CMD_CLEAR_ALL = 2'd1;
  localparam logic [1:0] CMD_CLEAR_INT = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_SETPOINT   = 3'd3;
  localparam logic [2:0] REG_FINISH_BND = 3'd4;

  // Integral saturation bounds and the clamp applied to the integral product.
  localparam logic signed [47:0] INTEG_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] INTEG_MIN   = 48'sh8000_0000_0000;
  localparam logic [71:0]        ITERM_CLAMP = 72'h4_0000_0000_0000;

  // Drive limit of 2.0 in the Q.28 sum, and the rounding offset to Q3.14.
  localparam logic signed [52:0] LIMIT_POS = 53'sh0_0000_2000_0000;
  localparam logic signed [52:0] LIMIT_NEG = -53'sh0_0000_2000_0000;
  localparam logic signed [52:0] ROUND_OFS = 53'sh0_0000_0000_2000;

  // Configuration register set.
  typedef struct packed {
    logic signed [23:0] gain_p;
    logic signed [23:0] gain_i;
    logic signed [23:0] gain_d;
    logic signed [23:0] setpoint;
    logic        [22:0] finish_band;
  } pid_cfg_t;

  // Error terms after the state update.
  typedef struct packed {
    logic signed [24:0] err;
    logic signed [25:0] diff;
    logic signed [47:0] integ;
    logic               finished;
  } pid_s1_t;

  // Products; the integral product is kept as two unsigned partial products.
  typedef struct packed {
    logic signed [48:0] p_term;
    logic signed [49:0] d_term;
    logic        [47:0] i_lo;
    logic        [47:0] i_hi;
    logic               i_neg;
    logic               finished;
  } pid_s2_t;

  // Three signed terms ready for the final sum.
  typedef struct packed {
    logic signed [48:0] p_term;
    logic signed [49:0] d_term;
    logic signed [51:0] i_term;
    logic               finished;
  } pid_s3_t;

endpackage

>>> sv/pid_regs.sv
// Configuration register file behind an APB-style port.
// Depends on pid_pkg for the register indexes and the register set type.
module pid_regs
  import pid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output pid_cfg_t    cfg
);

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (index)
        REG_GAIN_P:     cfg.gain_p      <= pwdata[23:0];
        REG_GAIN_I:     cfg.gain_i      <= pwdata[23:0];
        REG_GAIN_D:     cfg.gain_d      <= pwdata[23:0];
        REG_SETPOINT:   cfg.setpoint    <= pwdata[23:0];
        REG_FINISH_BND: cfg.finish_band <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Read back, signed registers sign-extended.
  always_comb begin
    case (index)
      REG_GAIN_P:     prdata = 32'(cfg.gain_p);
      REG_GAIN_I:     prdata = 32'(cfg.gain_i);
      REG_GAIN_D:     prdata = 32'(cfg.gain_d);
      REG_SETPOINT:   prdata = 32'(cfg.setpoint);
      REG_FINISH_BND: prdata = {9'd0, cfg.finish_band};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> sv/pid_front.sv
// Input stage: error, derivative and saturating integral with the error state.
// Depends on pid_pkg for command codes, bounds and stage types.
module pid_front
  import pid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [23:0] measurement,
  input  pid_cfg_t           cfg,
  output logic               s1_valid,
  input  logic               s1_ready,
  output pid_s1_t            s1
);

  logic signed [24:0] last_error;
  logic signed [47:0] error_integral;
  logic signed [24:0] err;
  logic signed [25:0] diff;
  logic signed [48:0] integ_sum;
  logic signed [47:0] integ_next;
  logic        [24:0] err_mag;
  logic               accept;
  logic               stage_ready;

  assign stage_ready = !s1_valid || s1_ready;
  assign in_stall    = !stage_ready;
  assign accept      = in_valid && stage_ready;

  // Error against the target, its change, and the clamped running sum.
  always_comb begin
    err       = 25'(cfg.setpoint) - 25'(measurement);
    diff      = 26'(err) - 26'(last_error);
    integ_sum = 49'(error_integral) + 49'(err);
    if (integ_sum[48] != integ_sum[47]) begin
      integ_next = integ_sum[48] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_next = integ_sum[47:0];
    end
    err_mag = err[24] ? 25'(-err) : 25'(err);
  end

  // Error state moves with each accepted sample or clear command.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error     <= '0;
      error_integral <= '0;
    end else if (accept) begin
      case (cmd)
        CMD_SAMPLE: begin
          last_error     <= err;
          error_integral <= integ_next;
        end
        CMD_CLEAR_ALL: begin
          last_error     <= '0;
          error_integral <= '0;
        end
        CMD_CLEAR_INT: begin
          error_integral <= '0;
        end
        default: ;
      endcase
    end
  end

  // Only samples go on down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stage_ready) begin
      s1_valid <= accept && (cmd == CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_SAMPLE)) begin
      s1.err      <= err;
      s1.diff     <= diff;
      s1.integ    <= integ_next;
      s1.finished <= err_mag < {2'b00, cfg.finish_band};
    end
  end

endmodule

>>> sv/pid_mult.sv
// Multiply stage: proportional and derivative products, integral in two halves.
// Depends on pid_pkg for the register set and stage types.
module pid_mult
  import pid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  pid_cfg_t cfg,
  input  logic     s1_valid,
  output logic     s1_ready,
  input  pid_s1_t  s1,
  output logic     s2_valid,
  input  logic     s2_ready,
  output pid_s2_t  s2
);

  logic [23:0] gi_mag;
  logic [47:0] integ_mag;

  assign s1_ready = !s2_valid || s2_ready;

  // Magnitudes for the unsigned integral product.
  always_comb begin
    gi_mag    = cfg.gain_i[23] ? 24'(-cfg.gain_i) : 24'(cfg.gain_i);
    integ_mag = s1.integ[47] ? 48'(-s1.integ) : 48'(s1.integ);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2.p_term   <= 49'($signed(cfg.gain_p)) * 49'($signed(s1.err));
      s2.d_term   <= 50'($signed(cfg.gain_d)) * 50'($signed(s1.diff));
      s2.i_lo     <= 48'(gi_mag) * 48'(integ_mag[23:0]);
      s2.i_hi     <= 48'(gi_mag) * 48'(integ_mag[47:24]);
      s2.i_neg    <= cfg.gain_i[23] ^ s1.integ[47];
      s2.finished <= s1.finished;
    end
  end

endmodule

>>> sv/pid_out.sv
// Output stages: integral product assembly and clamp, then sum, limit and round.
// Depends on pid_pkg for limits and stage types.
module pid_out
  import pid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s2_valid,
  output logic               s2_ready,
  input  pid_s2_t            s2,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] drive,
  output logic               overrange,
  output logic               finished
);

  logic               s3_valid;
  logic               s3_ready;
  pid_s3_t            s3;
  logic [71:0]        i_full;
  logic [50:0]        i_mag;
  logic signed [52:0] sum;
  logic signed [52:0] rounded;
  logic               over;

  assign s2_ready = !s3_valid || s3_ready;
  assign s3_ready = !out_valid || !out_stall;

  // Join the partial products and clamp the magnitude at 2^50.
  always_comb begin
    i_full = {s2.i_hi, 24'd0} + {24'd0, s2.i_lo};
    i_mag  = (i_full > ITERM_CLAMP) ? ITERM_CLAMP[50:0] : i_full[50:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      s3.p_term   <= s2.p_term;
      s3.d_term   <= s2.d_term;
      s3.i_term   <= s2.i_neg ? -$signed({1'b0, i_mag}) : $signed({1'b0, i_mag});
      s3.finished <= s2.finished;
    end
  end

  // Exact sum, overrange test against 2.0, and round half up to Q3.14.
  always_comb begin
    sum     = 53'(s3.p_term) + 53'(s3.d_term) + 53'(s3.i_term);
    over    = (sum > LIMIT_POS) || (sum < LIMIT_NEG);
    rounded = (sum + ROUND_OFS) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_ready) begin
      drive     <= over ? '0 : rounded[17:0];
      overrange <= over;
      finished  <= s3.finished;
    end
  end

endmodule

>>> sv/pid_step_with_cutoff.sv
// PID step with drive cutoff: one result per sample command, and one sample
// accepted per cycle while in_stall is low.
// Clear commands act on the error state at their transfer and give no result.
// The stages are the error update, the multipliers, the integral clamp and the
// final sum with rounding. Reset clears the registers, the error state and the
// pipeline valid bits.
module pid_step_with_cutoff
  import pid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [23:0] measurement,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] drive,
  output logic               overrange,
  output logic               finished
);

  pid_cfg_t cfg;
  logic     s1_valid;
  logic     s1_ready;
  pid_s1_t  s1;
  logic     s2_valid;
  logic     s2_ready;
  pid_s2_t  s2;

  pid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pid_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .measurement (measurement),
    .cfg         (cfg),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1          (s1)
  );

  pid_mult u_mult (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2_ready (s2_ready),
    .s2       (s2)
  );

  pid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2        (s2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .overrange (overrange),
    .finished  (finished)
  );

`ifndef ASSERT_OFF
  // An overrange result carries a zero drive.
  a_cutoff_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && overrange |-> drive == 18'sd0)
    else $error("overrange result with nonzero drive");

  // An in-range drive never exceeds 2.0 after rounding.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !overrange |-> (drive >= -18'sd32768) && (drive <= 18'sd32768))
    else $error("drive outside the 2.0 limit");

  // No result is pending right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

>>> tb/tb_pid_step_with_cutoff.sv
// Self-checking testbench for pid_step_with_cutoff: a scoreboard class predicts
// every sample result and checks the result channel. Depends on pid_pkg and the DUT.
`timescale 1ns / 1ps

module tb_pid_step_with_cutoff
  import pid_pkg::*;
();

  // The block ignores this command code.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Saturation bounds, product clamp, drive limit and rounding offset.
  localparam longint ACC_MAX   = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_MIN   = -ACC_MAX - 1;
  localparam longint ITERM_LIM = 64'sh4_0000_0000_0000;
  localparam longint DRIVE_LIM = 64'sh2000_0000;
  localparam longint HALF_LSB  = 64'sh2000;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 82;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic signed [17:0] drive;
    logic               over;
    logic               fin;
  } pid_result_t;

  // Scoreboard: keeps its own registers and error state, and the queue of
  // expected results in the order they must leave the block.
  class pid_scoreboard;
    longint kp, ki, kd, target, band;
    longint last_err, integ;
    pid_result_t expected_q[$];
    int errors, samples, clears, ignored, checked, overs, fins, clamps;

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_GAIN_P:     kp = longint'($signed(val[23:0]));
        REG_GAIN_I:     ki = longint'($signed(val[23:0]));
        REG_GAIN_D:     kd = longint'($signed(val[23:0]));
        REG_SETPOINT:   target = longint'($signed(val[23:0]));
        REG_FINISH_BND: band = longint'(val[22:0]);
        default: ;
      endcase
    endfunction

    // Applies one accepted input transfer and queues its result, if any.
    function void note_input(logic [1:0] c, logic [23:0] m);
      longint err, diff, sum, mag_err;
      logic signed [127:0] wide_ki, wide_acc, iprod;
      pid_result_t r;
      case (c)
        CMD_CLEAR_ALL: begin
          last_err = 0;
          integ = 0;
          clears++;
        end
        CMD_CLEAR_INT: begin
          integ = 0;
          clears++;
        end
        CMD_SAMPLE: begin
          err = target - longint'($signed(m));
          diff = err - last_err;
          last_err = err;
          integ = integ + err;
          if (integ > ACC_MAX) integ = ACC_MAX;
          else if (integ < ACC_MIN) integ = ACC_MIN;

          // The integral product can exceed 64 bits, so form it wide and clamp.
          wide_ki = ki;
          wide_acc = integ;
          iprod = wide_ki * wide_acc;
          if (iprod > ITERM_LIM) begin
            iprod = ITERM_LIM;
            clamps++;
          end else if (iprod < -ITERM_LIM) begin
            iprod = -ITERM_LIM;
            clamps++;
          end
          sum = kp * err + longint'(iprod) + kd * diff;

          // Exactly 2.0 still passes; halves round toward plus infinity.
          r.over = (sum > DRIVE_LIM) || (sum < -DRIVE_LIM);
          r.drive = r.over ? 18'sd0 : 18'((sum + HALF_LSB) >>> 14);
          mag_err = (err < 0) ? -err : err;
          r.fin = (mag_err < band);
          expected_q.push_back(r);
          samples++;
          if (r.over) overs++;
          if (r.fin) fins++;
        end
        default: ignored++;
      endcase
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(logic signed [17:0] d, logic o, logic f);
      pid_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: drive=%0d overrange=%0b finished=%0b",
                 $time, d, o, f);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (d !== want.drive) begin
        errors++;
        $display("%0t: drive mismatch, expected %0d, got %0d", $time, want.drive, d);
      end
      if (o !== want.over) begin
        errors++;
        $display("%0t: overrange mismatch, expected %0b, got %0b", $time, want.over, o);
      end
      if (f !== want.fin) begin
        errors++;
        $display("%0t: finished mismatch, expected %0b, got %0b", $time, want.fin, f);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         cmd;
  logic signed [23:0] measurement;
  logic               out_valid;
  logic               out_stall;
  logic signed [17:0] drive;
  logic               overrange;
  logic               finished;

  pid_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;
  logic [23:0] cur_sp = '0;

  pid_step_with_cutoff u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .measurement(measurement),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive(drive), .overrange(overrange), .finished(finished)
  );

  always #2 clk = ~clk;

  // Receiver side: random stall decided at each falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall);
  end

  // Result monitor: every result transfer is checked against the scoreboard.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(drive, overrange, finished);
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** pid_step_with_cutoff: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apply_cfg(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                           logic [23:0] sp, logic [22:0] band);
    write_reg(REG_GAIN_P, {8'b0, kp});
    write_reg(REG_GAIN_I, {8'b0, ki});
    write_reg(REG_GAIN_D, {8'b0, kd});
    write_reg(REG_SETPOINT, {8'b0, sp});
    write_reg(REG_FINISH_BND, {9'b0, band});
    cur_sp = sp;
  endtask

  // Sends one input item, with random idle cycles ahead of it.
  task automatic send_item(logic [1:0] c, logic [23:0] m);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    measurement <= m;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, m);
  endtask

  // Lowers valid and waits for every expected result to arrive.
  task automatic wait_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Full drain, then an idle wait so clears have settled as well.
  task automatic drain();
    wait_results();
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [23:0] rand_signed(int span);
    return 24'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  initial begin
    int counted;
    int r;
    int span;
    logic [23:0] m;

    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    cmd = CMD_SAMPLE;
    measurement = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Unit proportional gain: drive limit at exactly 2.0, finish band edges,
    // measurement extremes and both clear commands.
    apply_cfg(24'h01_0000, 24'h0, 24'h0, 24'h0, 23'd4096);
    send_item(CMD_SAMPLE, 24'sd8192);
    send_item(CMD_SAMPLE, -24'sd8192);
    send_item(CMD_SAMPLE, -24'sd8193);
    send_item(CMD_SAMPLE, 24'sd0);
    send_item(CMD_SAMPLE, -24'sd4096);
    send_item(CMD_SAMPLE, 24'sd4095);
    send_item(CMD_SAMPLE, 24'h80_0000);
    send_item(CMD_SAMPLE, 24'h7F_FFFF);
    send_item(CMD_CLEAR_ALL, 24'h0);
    send_item(CMD_CLEAR_INT, 24'hFF_FFFF);
    drain();

    // Smallest gain: sums of exactly half an output step, both signs.
    apply_cfg(24'h00_0001, 24'h0, 24'h0, 24'h0, 23'd0);
    send_item(CMD_SAMPLE, -24'sd8192);
    send_item(CMD_SAMPLE, 24'sd8192);
    drain();

    // Extreme gains and largest error: the integral product hits its clamp
    // after nine samples. Then integral clear, ignored command and full clear.
    apply_cfg(24'h00_0001, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 23'h7F_FFFF);
    repeat (9) send_item(CMD_SAMPLE, 24'h80_0000);
    send_item(CMD_CLEAR_INT, 24'h0);
    send_item(CMD_SAMPLE, 24'h80_0000);
    send_item(CMD_UNUSED, 24'h80_0000);
    send_item(CMD_CLEAR_ALL, 24'h0);
    send_item(CMD_SAMPLE, 24'h7F_FFFF);
    drain();

    // Random phases, each with its own settings and idle pattern. Integral
    // saturation itself needs millions of samples and is not reached here.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        1: begin
          apply_cfg(24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 23'd0);
          span = 1 << 20;
        end
        4: begin
          apply_cfg(24'h80_0000, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 23'h7F_FFFF);
          span = 1 << 20;
        end
        default: begin
          apply_cfg(rand_signed(1 << 17), rand_signed(1 << 9), rand_signed(1 << 15),
                    24'($urandom()), 23'($urandom_range(0, 1 << 13)));
          span = 1 << 12;
        end
      endcase
      case (p % 4)
        0: begin
          send_idle = 0;
          recv_stall = 0;
        end
        1: begin
          send_idle = 88;
          recv_stall = 0;
        end
        2: begin
          send_idle = 0;
          recv_stall = 88;
        end
        default: begin
          send_idle = 36;
          recv_stall = 36;
        end
      endcase

      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 68) begin
          // Measurement close to the target keeps the drive mostly in range.
          m = cur_sp + rand_signed(span);
          send_item(CMD_SAMPLE, m);
          counted++;
        end else if (r < 83) begin
          send_item(CMD_SAMPLE, 24'($urandom()));
          counted++;
        end else if (r < 94) begin
          send_item($urandom_range(1) ? CMD_CLEAR_ALL : CMD_CLEAR_INT, 24'($urandom()));
          counted++;
        end else begin
          send_item(CMD_UNUSED, 24'($urandom()));
        end
        // Hold the sender back once per phase until the pipeline is empty.
        if (counted == ITEMS_PER_PHASE / 2 && r < 94) wait_results();
      end
      drain();
      send_idle = 0;
      recv_stall = 0;
    end

    // Final drain, then a few more cycles to catch stray results.
    wait_results();
    repeat (10) @(negedge clk);
    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    end

    $display("Checked %0d of %0d sample results: %0d overrange, %0d finished, %0d clamped",
             sb.checked, sb.samples, sb.overs, sb.fins, sb.clamps);
    $display("integral terms; %0d clear commands and %0d ignored commands, %0d mismatches.",
             sb.clears, sb.ignored, sb.errors);
    if (sb.errors == 0) begin
      $display("** pid_step_with_cutoff: PASSED **");
    end else begin
      $display("** pid_step_with_cutoff: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pid_pkg.sv
sv/pid_regs.sv
sv/pid_front.sv
sv/pid_mult.sv
sv/pid_out.sv
sv/pid_step_with_cutoff.sv
tb/tb_pid_step_with_cutoff.sv
